FILE: rtl/core/lcp_pkg.sv
// Shared types and constants for the LED chase pattern generator.
// No dependencies; imported by lcp_step and the top level.
`timescale 1ns / 1ps

package lcp_pkg;

    localparam int LED_W  = 32;
    localparam int HALF_W = 16;
    localparam int MODE_W = 3;
    localparam int STEP_W = 6;
    localparam int KEY_W  = 4;

    localparam logic [LED_W-1:0]  ALL_ON  = 32'hffff_ffff;
    localparam logic [LED_W-1:0]  TOP_BIT = 32'h8000_0000;
    localparam logic [LED_W-1:0]  LOW_BIT = 32'h0000_0001;
    localparam logic [HALF_W-1:0] HALF_ON = 16'hffff;

    localparam logic [STEP_W-1:0] FULL_LAST = 6'd32;
    localparam logic [STEP_W-1:0] HALF_LAST = 6'd16;
    localparam logic [STEP_W-1:0] DOT_LAST  = 6'd31;
    localparam logic [STEP_W-1:0] DOT_SPAN  = 6'd32;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_KEY  = 1'b1;

    localparam logic [KEY_W-1:0] KEY_FIRST = 4'd1;
    localparam logic [KEY_W-1:0] KEY_LAST  = 4'd6;
    localparam logic [KEY_W-1:0] KEY_STOP  = 4'd7;

    localparam logic [MODE_W-1:0] MODE_BLINK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FILL_UP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FILL_DOWN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HALF_IN    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HALF_OUT   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STACK_LOW  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_STACK_HIGH = 3'd6;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              half;
        logic [STEP_W-1:0] outer;
        logic [STEP_W-1:0] inner;
        logic [LED_W-1:0]  leds;
    } t_state;

endpackage

FILE: rtl/core/lcp_step.sv
// Next-state logic for one beat: key handling and one pattern frame per tick.
// Depends on lcp_pkg.
`timescale 1ns / 1ps

module lcp_step
    import lcp_pkg::*;
(
    input  t_state             i_cur,
    input  logic               i_kind,
    input  logic [KEY_W-1:0]   i_key,
    output t_state             o_nxt
);

    always_comb begin
        logic [STEP_W-1:0] n;
        logic [STEP_W-1:0] n1;
        logic [STEP_W-1:0] i;
        logic [STEP_W-1:0] i1;
        logic [STEP_W-1:0] lim;
        logic [LED_W-1:0]  lo32;
        logic [HALF_W-1:0] lo16;
        logic [HALF_W-1:0] hi16;
        logic [HALF_W-1:0] shl16;
        logic [HALF_W-1:0] shr16;
        logic              sel;
        logic [MODE_W-1:0] pick;

        o_nxt = i_cur;
        n     = '0;
        n1    = '0;
        i     = '0;
        i1    = '0;
        lim   = '0;
        lo32  = '0;
        lo16  = '0;
        hi16  = '0;
        shl16 = '0;
        shr16 = '0;
        sel   = 1'b0;
        pick  = MODE_BLINK;

        if (i_kind == KIND_KEY) begin
            if (i_key inside {[KEY_FIRST:KEY_LAST]}) begin
                sel  = 1'b1;
                pick = i_key[MODE_W-1:0];
            end else if (i_key == KEY_STOP) begin
                sel  = 1'b1;
                pick = MODE_BLINK;
            end
            if (sel && (pick != i_cur.mode)) begin
                o_nxt.mode  = pick;
                o_nxt.half  = 1'b0;
                o_nxt.outer = '0;
                o_nxt.inner = '0;
                o_nxt.leds  = '0;
            end
        end else begin
            case (i_cur.mode)
                MODE_BLINK: begin
                    o_nxt.leds = ~i_cur.leds;
                end
                MODE_FILL_UP, MODE_FILL_DOWN: begin
                    n = (i_cur.inner > FULL_LAST) ? '0 : i_cur.inner;
                    if (n >= FULL_LAST) begin
                        lo32 = '0;
                    end else if (i_cur.mode == MODE_FILL_UP) begin
                        lo32 = ALL_ON << n[4:0];
                    end else begin
                        lo32 = ALL_ON >> n[4:0];
                    end
                    o_nxt.leds = i_cur.half ? lo32 : ~lo32;
                    n1 = n + 6'd1;
                    if (n1 > FULL_LAST) begin
                        o_nxt.inner = '0;
                        o_nxt.half  = ~i_cur.half;
                    end else begin
                        o_nxt.inner = n1;
                    end
                end
                MODE_HALF_IN, MODE_HALF_OUT: begin
                    n = (i_cur.inner > HALF_LAST) ? '0 : i_cur.inner;
                    shl16 = (n >= HALF_LAST) ? '0 : (HALF_ON << n[3:0]);
                    shr16 = (n >= HALF_LAST) ? '0 : (HALF_ON >> n[3:0]);
                    if (i_cur.mode == MODE_HALF_IN) begin
                        lo16 = shl16;
                        hi16 = shr16;
                    end else begin
                        lo16 = shr16;
                        hi16 = shl16;
                    end
                    if (!i_cur.half) begin
                        lo16 = ~lo16;
                        hi16 = ~hi16;
                    end
                    o_nxt.leds = {hi16, lo16};
                    n1 = n + 6'd1;
                    if (n1 > HALF_LAST) begin
                        o_nxt.inner = '0;
                        o_nxt.half  = ~i_cur.half;
                    end else begin
                        o_nxt.inner = n1;
                    end
                end
                MODE_STACK_LOW, MODE_STACK_HIGH: begin
                    i   = (i_cur.outer > DOT_LAST) ? '0 : i_cur.outer;
                    lim = DOT_SPAN - i;
                    n   = (i_cur.inner >= lim) ? '0 : i_cur.inner;
                    if (i_cur.mode == MODE_STACK_LOW) begin
                        o_nxt.leds = ~(ALL_ON << i[4:0]) | (TOP_BIT >> n[4:0]);
                    end else begin
                        o_nxt.leds = ~(ALL_ON >> i[4:0]) | (LOW_BIT << n[4:0]);
                    end
                    n1 = n + 6'd1;
                    if (n1 >= lim) begin
                        i1 = i + 6'd1;
                        o_nxt.inner = '0;
                        o_nxt.outer = (i1 > DOT_LAST) ? '0 : i1;
                    end else begin
                        o_nxt.inner = n1;
                        o_nxt.outer = i;
                    end
                end
                default: begin
                    o_nxt = i_cur;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/led_chase_pattern_generator.sv
// LED chase pattern generator top level: input register, pattern state, result register.
// An accepted beat waits in the input register until the result register is free.
// Throughput: one beat per cycle while the output is not stalled; lcp_step is combinational.
// Reset (synchronous, active low): blink mode, all counters zero, all LEDs off, no beats held.
// Depends on lcp_pkg and lcp_step.
`timescale 1ns / 1ps

module led_chase_pattern_generator
    import lcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [LED_W-1:0]  o_led_pattern,
    output logic [MODE_W-1:0] o_active_mode
);

    logic              r_in_valid;
    logic              r_kind;
    logic [KEY_W-1:0]  r_key;
    t_state            r_state;
    t_state            n_state;
    logic              r_out_valid;
    logic [LED_W-1:0]  r_led;
    logic [MODE_W-1:0] r_mode;
    logic              w_adv;

    lcp_step u_step (
        .i_cur  (r_state),
        .i_kind (r_kind),
        .i_key  (r_key),
        .o_nxt  (n_state)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_kind;
            r_key  <= i_key;
        end
        if (w_adv) begin
            r_led  <= n_state.leds;
            r_mode <= n_state.mode;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_pattern = r_led;
    assign o_active_mode = r_mode;

endmodule

FILE: tb/tb_led_chase_pattern_generator.sv
// Self-checking testbench for led_chase_pattern_generator: a directed table, a full stack run, then random
// key and tick traffic with bursty input and a stalling output, checked by a frame predictor.
// Depends on lcp_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_led_chase_pattern_generator;
    import lcp_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 40;
    localparam int STACK_FRAMES  = 530;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int DIRECTED_ROWS = 25;

    localparam logic [KEY_W-1:0] KEY_IDLE       = 4'd0;
    localparam logic [KEY_W-1:0] KEY_FILL_UP    = 4'd1;
    localparam logic [KEY_W-1:0] KEY_FILL_DOWN  = 4'd2;
    localparam logic [KEY_W-1:0] KEY_HALF_IN    = 4'd3;
    localparam logic [KEY_W-1:0] KEY_HALF_OUT   = 4'd4;
    localparam logic [KEY_W-1:0] KEY_STACK_LOW  = 4'd5;
    localparam logic [KEY_W-1:0] KEY_STACK_HIGH = 4'd6;
    localparam logic [KEY_W-1:0] KEY_ABOVE      = 4'd8;
    localparam logic [KEY_W-1:0] KEY_MID        = 4'd10;
    localparam logic [KEY_W-1:0] KEY_ALT        = 4'd5;
    localparam logic [KEY_W-1:0] KEY_MAX        = 4'd15;

    typedef struct packed {
        logic [LED_W-1:0]  leds;
        logic [MODE_W-1:0] mode;
    } t_led_frame;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  key;
        logic              fixed;
        logic [LED_W-1:0]  leds;
        logic [MODE_W-1:0] mode;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_kind;
    logic [KEY_W-1:0]  i_key;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [LED_W-1:0]  o_led_pattern;
    logic [MODE_W-1:0] o_active_mode;

    led_chase_pattern_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_led_pattern (o_led_pattern),
        .o_active_mode (o_active_mode)
    );

    // predicted pattern state
    logic [MODE_W-1:0] pat_mode;
    logic              pat_half;
    logic [STEP_W-1:0] pat_outer;
    logic [STEP_W-1:0] pat_inner;
    logic [LED_W-1:0]  pat_leds;

    t_led_frame frames_due[$];
    t_stim_row  directed_rows [DIRECTED_ROWS];

    int n_errors   = 0;
    int n_beats_in = 0;
    int n_frames   = 0;
    int n_keys     = 0;
    int burst_left = 0;
    logic [6:0] modes_seen = '0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void clear_pattern();
        pat_half  = 1'b0;
        pat_outer = '0;
        pat_inner = '0;
        pat_leds  = '0;
    endfunction

    function automatic void advance_pattern(input logic kind, input logic [KEY_W-1:0] key);
        int unsigned       n;
        int unsigned       i;
        logic [MODE_W-1:0] next_mode;
        logic [LED_W-1:0]  full;
        logic [HALF_W-1:0] up16;
        logic [HALF_W-1:0] dn16;
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
        n = pat_inner;
        i = pat_outer;
        if (kind == KIND_KEY) begin
            if (key >= KEY_FIRST && key <= KEY_LAST) begin
                next_mode = key[MODE_W-1:0];
            end else if (key == KEY_STOP) begin
                next_mode = MODE_BLINK;
            end else begin
                return;
            end
            if (next_mode != pat_mode) begin
                pat_mode = next_mode;
                clear_pattern();
            end
            return;
        end
        case (pat_mode)
            MODE_BLINK: begin
                pat_leds = ~pat_leds;
            end
            MODE_FILL_UP, MODE_FILL_DOWN: begin
                if (n > 32) n = 0;
                if (n >= 32) full = '0;
                else if (pat_mode == MODE_FILL_UP) full = ALL_ON << n;
                else full = ALL_ON >> n;
                pat_leds = pat_half ? full : ~full;
                n++;
                if (n > 32) begin
                    n = 0;
                    pat_half = ~pat_half;
                end
                pat_inner = n[STEP_W-1:0];
            end
            MODE_HALF_IN, MODE_HALF_OUT: begin
                if (n > 16) n = 0;
                up16 = (n >= 16) ? '0 : HALF_ON << n;
                dn16 = (n >= 16) ? '0 : HALF_ON >> n;
                lo = (pat_mode == MODE_HALF_IN) ? up16 : dn16;
                hi = (pat_mode == MODE_HALF_IN) ? dn16 : up16;
                if (!pat_half) begin
                    lo = ~lo;
                    hi = ~hi;
                end
                pat_leds = {hi, lo};
                n++;
                if (n > 16) begin
                    n = 0;
                    pat_half = ~pat_half;
                end
                pat_inner = n[STEP_W-1:0];
            end
            MODE_STACK_LOW, MODE_STACK_HIGH: begin
                if (i > 31) i = 0;
                if (n >= 32 - i) n = 0;
                if (pat_mode == MODE_STACK_LOW) pat_leds = ~(ALL_ON << i) | (TOP_BIT >> n);
                else pat_leds = ~(ALL_ON >> i) | (LOW_BIT << n);
                n++;
                if (n >= 32 - i) begin
                    n = 0;
                    i++;
                    if (i > 31) i = 0;
                end
                pat_inner = n[STEP_W-1:0];
                pat_outer = i[STEP_W-1:0];
            end
            default: ;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] key_for_mode(input logic [MODE_W-1:0] mode);
        return (mode == MODE_BLINK) ? KEY_STOP : {1'b0, mode};
    endfunction

    // enter and leave at a falling edge; idle the input between most bursts
    task automatic send_beat(input logic kind, input logic [KEY_W-1:0] key,
                             input logic fixed, input logic [LED_W-1:0] fixed_leds,
                             input logic [MODE_W-1:0] fixed_mode);
        int         gap;
        t_led_frame frame;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        do @(posedge i_clk); while (!o_in_ready);
        advance_pattern(kind, key);
        frame.leds = fixed ? fixed_leds : pat_leds;
        frame.mode = fixed ? fixed_mode : pat_mode;
        frames_due.push_back(frame);
        n_beats_in++;
        if (kind == KIND_KEY) n_keys++;
        modes_seen[pat_mode] = 1'b1;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_beat(KIND_TICK, KEY_W'($urandom_range(0, 15)), 1'b0, '0, MODE_BLINK);
    endtask

    task automatic send_key(input logic [KEY_W-1:0] key);
        send_beat(KIND_KEY, key, 1'b0, '0, MODE_BLINK);
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_led_frame want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_frames++;
            if (frames_due.size() == 0) begin
                $error("unexpected beat: led_pattern=%h active_mode=%0d",
                       o_led_pattern, o_active_mode);
                n_errors++;
            end else begin
                want = frames_due.pop_front();
                if (o_led_pattern !== want.leds) begin
                    $error("led_pattern: expected %h, got %h", want.leds, o_led_pattern);
                    n_errors++;
                end
                if (o_active_mode !== want.mode) begin
                    $error("active_mode: expected %0d, got %0d", want.mode, o_active_mode);
                    n_errors++;
                end
            end
        end
    end

    // receiver backpressure, one style per stretch
    initial begin
        int style;
        int len;
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            style = $urandom_range(0, 3);
            len   = $urandom_range(10, 80);
            stall = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                @(negedge i_clk);
                case (style)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= $urandom_range(0, 1);
                    2: i_out_ready <= (k % 3 == 0);
                    default: i_out_ready <= (k >= stall);
                endcase
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        int idle_cycles;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int               items_done;
        int               pick;
        int               run;
        logic [KEY_W-1:0] key;
        t_stim_row        row;

        directed_rows = '{
            '{KIND_TICK, KEY_IDLE,       1'b1, ALL_ON, MODE_BLINK},
            '{KIND_TICK, KEY_MAX,        1'b1, '0,     MODE_BLINK},
            '{KIND_KEY,  KEY_IDLE,       1'b1, '0,     MODE_BLINK},
            '{KIND_KEY,  KEY_MAX,        1'b1, '0,     MODE_BLINK},
            '{KIND_KEY,  KEY_ABOVE,      1'b1, '0,     MODE_BLINK},
            '{KIND_TICK, KEY_MID,        1'b1, ALL_ON, MODE_BLINK},
            '{KIND_KEY,  KEY_FILL_UP,    1'b1, '0,     MODE_FILL_UP},
            '{KIND_TICK, KEY_ALT,        1'b0, '0,     MODE_BLINK},
            '{KIND_TICK, KEY_MAX,        1'b0, '0,     MODE_BLINK},
            '{KIND_KEY,  KEY_FILL_UP,    1'b0, '0,     MODE_BLINK},
            '{KIND_TICK, KEY_IDLE,       1'b0, '0,     MODE_BLINK},
            '{KIND_KEY,  KEY_FILL_DOWN,  1'b1, '0,     MODE_FILL_DOWN},
            '{KIND_TICK, KEY_MID,        1'b0, '0,     MODE_BLINK},
            '{KIND_TICK, KEY_ALT,        1'b0, '0,     MODE_BLINK},
            '{KIND_KEY,  KEY_HALF_IN,    1'b1, '0,     MODE_HALF_IN},
            '{KIND_TICK, KEY_MAX,        1'b0, '0,     MODE_BLINK},
            '{KIND_KEY,  KEY_HALF_OUT,   1'b1, '0,     MODE_HALF_OUT},
            '{KIND_TICK, KEY_IDLE,       1'b0, '0,     MODE_BLINK},
            '{KIND_KEY,  KEY_STACK_LOW,  1'b1, '0,     MODE_STACK_LOW},
            '{KIND_TICK, KEY_MID,        1'b0, '0,     MODE_BLINK},
            '{KIND_TICK, KEY_ALT,        1'b0, '0,     MODE_BLINK},
            '{KIND_KEY,  KEY_STACK_HIGH, 1'b1, '0,     MODE_STACK_HIGH},
            '{KIND_TICK, KEY_MAX,        1'b0, '0,     MODE_BLINK},
            '{KIND_KEY,  KEY_STOP,       1'b1, '0,     MODE_BLINK},
            '{KIND_TICK, KEY_IDLE,       1'b1, ALL_ON, MODE_BLINK}
        };

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_kind     = KIND_TICK;
        i_key      = KEY_IDLE;
        pat_mode   = MODE_BLINK;
        clear_pattern();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            send_beat(row.kind, row.key, row.fixed, row.leds, row.mode);
        end

        // one full stack cycle so the stack height wraps
        send_key($urandom_range(0, 1) ? KEY_STACK_LOW : KEY_STACK_HIGH);
        repeat (STACK_FRAMES) send_tick();

        items_done = 0;
        while (items_done < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                send_key(key_for_mode(MODE_W'($urandom_range(0, 6))));
                items_done++;
            end else if (pick == 7) begin
                key = KEY_W'($urandom_range(KEY_STOP, KEY_MAX));
                send_key((key == KEY_STOP) ? KEY_IDLE : key);
            end else if (pick == 8) begin
                send_key(key_for_mode(pat_mode));
            end
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 140)
                                              : $urandom_range(1, 40);
            repeat (run) begin
                send_tick();
                items_done++;
            end
        end

        i_in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d input beats (%0d key presses), checked %0d frames.",
                 n_beats_in, n_keys, n_frames);
        $display("Patterns visited (bit per mode): %b", modes_seen);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/lcp_pkg.sv
rtl/core/lcp_step.sv
rtl/core/led_chase_pattern_generator.sv
tb/tb_led_chase_pattern_generator.sv
